// ----- sv/lsbx_pkg.sv -----
// Shared types and constants of the LSB payload extractor.
package lsbx_pkg;

	localparam int unsigned MAX_MAGIC_CHARS = 8;
	localparam int unsigned HDR_LEN_W       = 10;
	localparam int unsigned MAGIC_LEN_W     = 4;
	localparam int unsigned MAGIC_WORD_W    = 64;
	localparam int unsigned CFG_IDX_W       = 2;
	localparam int unsigned MAGIC_SEL_W     = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_LEN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD = 2'd2;

	typedef enum logic [1:0] {
		KIND_EXT      = 2'd0,
		KIND_PAYLOAD  = 2'd1,
		KIND_MISMATCH = 2'd2,
		KIND_DONE     = 2'd3
	} kind_t;

	// The header skip phase lives in the front end; the back end never holds it.
	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_MAGIC   = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_EXT     = 3'd3,
		PH_PAYLEN  = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_IDLE    = 3'd6
	} phase_t;

	typedef struct packed {
		logic [7:0] carrier_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] result_byte;
		kind_t      result_kind;
		logic       last;
	} out_item_t;

	// One hidden bit passed from the front to the back.
	typedef struct packed {
		logic data_bit;
		logic restart;
	} bit_entry_t;

	typedef struct packed {
		logic [MAGIC_LEN_W-1:0]  magic_len;
		logic [MAGIC_WORD_W-1:0] magic_word;
	} magic_cfg_t;

endpackage

// ----- sv/lsbx_fifo.sv -----
// Small first-in first-out queue with full and empty flags.
module lsbx_fifo #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- sv/lsbx_front.sv -----
// Front end: accepts carrier bytes, drops header bytes and forwards hidden bits.
module lsbx_front
	import lsbx_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  in_item_t             item,
	input  logic [HDR_LEN_W-1:0] header_len,
	input  logic                 bq_full,
	output logic                 bq_push,
	output bit_entry_t           bq_entry
);

	logic [HDR_LEN_W-1:0] hdr_cnt_q, hdr_cnt_e;
	logic                 in_hdr_q, in_hdr_e;
	logic                 restart_pend_q;
	logic                 accept, is_header;

	assign accept    = push && !bq_full;
	assign in_hdr_e  = item.frame_start || in_hdr_q;
	assign hdr_cnt_e = item.frame_start ? '0 : hdr_cnt_q;
	assign is_header = in_hdr_e && (hdr_cnt_e < header_len);

	assign bq_push           = accept && !is_header;
	assign bq_entry.data_bit = item.carrier_byte[0];
	assign bq_entry.restart  = item.frame_start || restart_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q      <= '0;
			in_hdr_q       <= 1'b1;
			restart_pend_q <= 1'b1;
		end else if (accept) begin
			if (is_header) begin
				hdr_cnt_q      <= hdr_cnt_e + HDR_LEN_W'(1);
				in_hdr_q       <= 1'b1;
				restart_pend_q <= restart_pend_q || item.frame_start;
			end else begin
				in_hdr_q       <= 1'b0;
				restart_pend_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/lsbx_back.sv -----
// Back end: decodes the hidden bit stream into magic check, lengths and characters.
module lsbx_back
	import lsbx_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       bq_empty,
	input  bit_entry_t bq_entry,
	output logic       bq_pop,
	input  logic       rq_full,
	output logic       rq_push,
	output out_item_t  rq_item,
	input  magic_cfg_t cfg
);

	localparam int unsigned CNT_W = $clog2(LENGTH_BITS);
	localparam int unsigned L     = LENGTH_BITS;

	phase_t                 phase_q, phase_e, phase_d;
	logic [CNT_W-1:0]       bit_cnt_q, bit_cnt_e, bit_cnt_d;
	logic [L-1:0]           shift_q, shift_e, shift_d, shifted;
	logic [MAGIC_LEN_W-1:0] idx_q, idx_e, idx_d, idx_next, mlen;
	logic                   bad_q, bad_e, bad_d, bad_next;
	logic [L-1:0]           rem_q, rem_d;
	logic                   step, char_end, len_end, rem_last, len_zero;
	logic [MAGIC_SEL_W-1:0] sel;
	logic [7:0]             exp_char, ch;

	assign step   = !bq_empty && !rq_full;
	assign bq_pop = step;
	assign mlen   = (cfg.magic_len > MAGIC_LEN_W'(MAX_MAGIC_CHARS)) ?
	                MAGIC_LEN_W'(MAX_MAGIC_CHARS) : cfg.magic_len;

	// Effective state for this bit: a restart opens the magic phase, and an
	// empty magic string passes straight on to the extension length.
	always_comb begin
		phase_e   = phase_q;
		bit_cnt_e = bit_cnt_q;
		shift_e   = shift_q;
		idx_e     = idx_q;
		bad_e     = bad_q;
		if (bq_entry.restart) begin
			phase_e   = PH_MAGIC;
			bit_cnt_e = '0;
			shift_e   = '0;
			idx_e     = '0;
			bad_e     = 1'b0;
		end
		if (phase_e == PH_MAGIC && mlen == '0) begin
			phase_e   = PH_EXTLEN;
			bit_cnt_e = '0;
			shift_e   = '0;
			idx_e     = '0;
		end
		shifted  = {shift_e[L-2:0], bq_entry.data_bit};
		ch       = shifted[7:0];
		char_end = (bit_cnt_e == CNT_W'(7));
		len_end  = (bit_cnt_e == CNT_W'(L - 1));
		len_zero = (shifted == '0);
		rem_last = (rem_q == L'(1));
		sel      = MAGIC_SEL_W'(mlen - MAGIC_LEN_W'(1) - idx_e);
		exp_char = cfg.magic_word[{sel, 3'b000} +: 8];
		bad_next = bad_e || ((idx_e < mlen) && (exp_char != ch));
		idx_next = idx_e + MAGIC_LEN_W'(1);
	end

	// Next state.
	always_comb begin
		phase_d   = phase_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		idx_d     = idx_q;
		bad_d     = bad_q;
		rem_d     = rem_q;
		if (step) begin
			phase_d   = phase_e;
			bit_cnt_d = bit_cnt_e + CNT_W'(1);
			shift_d   = shifted;
			idx_d     = idx_e;
			bad_d     = bad_e;
			case (phase_e)
				PH_MAGIC: begin
					if (char_end) begin
						bit_cnt_d = '0;
						shift_d   = '0;
						idx_d     = idx_next;
						bad_d     = bad_next;
						if (idx_next >= mlen) begin
							phase_d = bad_next ? PH_IDLE : PH_EXTLEN;
							idx_d   = '0;
						end
					end
				end
				PH_EXTLEN, PH_PAYLEN: begin
					if (len_end) begin
						bit_cnt_d = '0;
						shift_d   = '0;
						idx_d     = '0;
						rem_d     = shifted;
						if (phase_e == PH_EXTLEN) begin
							phase_d = len_zero ? PH_PAYLEN : PH_EXT;
						end else begin
							phase_d = len_zero ? PH_IDLE : PH_PAYLOAD;
						end
					end
				end
				PH_EXT, PH_PAYLOAD: begin
					if (char_end) begin
						bit_cnt_d = '0;
						shift_d   = '0;
						rem_d     = rem_q - L'(1);
						if (rem_last) begin
							phase_d = (phase_e == PH_EXT) ? PH_PAYLEN : PH_IDLE;
						end
					end
				end
				default: begin
					phase_d   = PH_IDLE;
					bit_cnt_d = bit_cnt_q;
					shift_d   = shift_q;
				end
			endcase
		end
	end

	// Result generation.
	always_comb begin
		rq_push = 1'b0;
		rq_item = '{result_byte: 8'd0, result_kind: KIND_EXT, last: 1'b0};
		if (step) begin
			case (phase_e)
				PH_MAGIC: begin
					if (char_end && idx_next >= mlen && bad_next) begin
						rq_push = 1'b1;
						rq_item = '{result_byte: 8'd0, result_kind: KIND_MISMATCH, last: 1'b1};
					end
				end
				PH_PAYLEN: begin
					if (len_end && len_zero) begin
						rq_push = 1'b1;
						rq_item = '{result_byte: 8'd0, result_kind: KIND_DONE, last: 1'b1};
					end
				end
				PH_EXT: begin
					if (char_end) begin
						rq_push = 1'b1;
						rq_item = '{result_byte: ch, result_kind: KIND_EXT, last: 1'b0};
					end
				end
				PH_PAYLOAD: begin
					if (char_end) begin
						rq_push = 1'b1;
						rq_item = '{result_byte: ch, result_kind: KIND_PAYLOAD,
						            last: rem_last};
					end
				end
				default: begin
					rq_push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_cnt_q <= '0;
			shift_q   <= '0;
			idx_q     <= '0;
			bad_q     <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			bit_cnt_q <= bit_cnt_d;
			shift_q   <= shift_d;
			idx_q     <= idx_d;
			bad_q     <= bad_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_d;
	end

	// Character phases always have at least one character left to deliver.
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EXT || phase_q == PH_PAYLOAD) |-> (rem_q != '0))
		else $error("character phase entered with no characters left");

	// A final result always leaves the decoder idle.
	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(rq_push && rq_item.last) |=> (phase_q == PH_IDLE))
		else $error("decoder not idle after a final result");

	// No result is produced while the result queue cannot take it.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rq_full |-> !rq_push && !bq_pop)
		else $error("decoder stepped while the result queue was full");

endmodule

// ----- sv/lsb_stego_payload_extractor.sv -----
// Top level of the LSB steganography payload extractor.
//
// Carrier image bytes enter through a queue-like port: a transaction takes
// place at a rising edge with push high and full low. Results leave through
// a second queue-like port: the oldest result sits on result while empty is
// low and is taken at an edge with pop high. Configuration registers
// (header length, magic length, magic word) are written through cfg_we,
// cfg_idx and cfg_data, one register per cycle, with no read-back.
// The front end drops header bytes and passes the least significant bit of
// every later byte, tagged with a restart mark, through a two-entry queue to
// the back end, which gathers characters and lengths and writes results into
// a two-entry result queue. A byte that completes a result shows it on the
// result port after it has passed through the bit queue and then the result
// queue. One byte is taken every cycle while full is low; the rate is set by
// the single-bit decode step in the back end.
// Reset loads the register defaults and starts in header skip, as after a
// frame start. When the receiver stops popping, the result queue fills, the
// back end halts, the bit queue fills and full rises; nothing is lost.
module lsb_stego_payload_extractor
	import lsbx_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  in_item_t                item,
	output logic                    empty,
	input  logic                    pop,
	output out_item_t               result,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_idx,
	input  logic [MAGIC_WORD_W-1:0] cfg_data
);

	localparam int unsigned BQ_DEPTH = 2;
	localparam int unsigned RQ_DEPTH = 2;

	logic [HDR_LEN_W-1:0] header_len_q;
	magic_cfg_t           magic_cfg_q;

	logic       bq_push, bq_full, bq_empty, bq_pop;
	bit_entry_t bq_wentry, bq_rentry;
	logic       rq_push, rq_full;
	out_item_t  rq_item;

	// Configuration registers; writes to an unused index are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_len_q           <= HDR_LEN_W'(54);
			magic_cfg_q.magic_len  <= MAGIC_LEN_W'(2);
			magic_cfg_q.magic_word <= MAGIC_WORD_W'(64'h230A);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_HEADER_LEN: header_len_q           <= cfg_data[HDR_LEN_W-1:0];
				CFG_MAGIC_LEN:  magic_cfg_q.magic_len  <= cfg_data[MAGIC_LEN_W-1:0];
				CFG_MAGIC_WORD: magic_cfg_q.magic_word <= cfg_data;
				default:        header_len_q           <= header_len_q;
			endcase
		end
	end

	// The input port stalls only when the bit queue has no room.
	assign full = bq_full;

	lsbx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.header_len (header_len_q),
		.bq_full    (bq_full),
		.bq_push    (bq_push),
		.bq_entry   (bq_wentry)
	);

	lsbx_fifo #(
		.WIDTH ($bits(bit_entry_t)),
		.DEPTH (BQ_DEPTH)
	) u_bit_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (bq_push),
		.wdata  (bq_wentry),
		.full   (bq_full),
		.pop    (bq_pop),
		.rdata  (bq_rentry),
		.empty  (bq_empty)
	);

	lsbx_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.bq_empty (bq_empty),
		.bq_entry (bq_rentry),
		.bq_pop   (bq_pop),
		.rq_full  (rq_full),
		.rq_push  (rq_push),
		.rq_item  (rq_item),
		.cfg      (magic_cfg_q)
	);

	lsbx_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (RQ_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (rq_item),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
